// ----- rtl/char_lcd_nibble_sequencer_unit_assert.svh -----
// Assertion macros shared by the character LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLNS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clns assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CLNS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clns assertion failed");

`endif

// ----- rtl/clns_pkg.sv -----
// Types, constants and the init command table of the LCD nibble sequencer.
package clns_pkg;

	localparam int CFG_W = 20;
	localparam int WAIT_AFTER_W = 21;
	localparam int REG_INDEX_W = 3;
	localparam int STEP_W = 4;

	// Request kinds.
	localparam logic [1:0] REQ_INIT     = 2'd0;
	localparam logic [1:0] REQ_COMMAND  = 2'd1;
	localparam logic [1:0] REQ_DATA     = 2'd2;
	localparam logic [1:0] REQ_POSITION = 2'd3;

	// Configuration register indexes.
	localparam logic [REG_INDEX_W-1:0] REG_COMMAND_PULSE      = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_DATA_PULSE         = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_COMMAND_SETTLE     = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_SLOW_COMMAND_EXTRA = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_POWER_UP_WAIT      = 3'd4;
	localparam logic [REG_INDEX_W-1:0] REG_INIT_SECOND_WAIT   = 3'd5;
	localparam logic [REG_INDEX_W-1:0] REG_DATA_GAP           = 3'd6;

	// Reset values of the timing registers.
	localparam logic [CFG_W-1:0] RST_COMMAND_PULSE      = 20'd3;
	localparam logic [CFG_W-1:0] RST_DATA_PULSE         = 20'd120;
	localparam logic [CFG_W-1:0] RST_COMMAND_SETTLE     = 20'd3000;
	localparam logic [CFG_W-1:0] RST_SLOW_COMMAND_EXTRA = 20'd9000;
	localparam logic [CFG_W-1:0] RST_POWER_UP_WAIT      = 20'd120000;
	localparam logic [CFG_W-1:0] RST_INIT_SECOND_WAIT   = 20'd30000;
	localparam logic [CFG_W-1:0] RST_DATA_GAP           = 20'd150000;

	localparam logic [7:0] SET_POSITION_BIT = 8'h80;
	localparam logic [7:0] SLOW_COMMAND_LIMIT = 8'h04;

	// Power-up nibbles and the init command sequence.
	localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
	localparam logic [7:0] CMD_CURSOR_SHIFT = 8'h16;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_RETURN_HOME  = 8'h02;

	localparam logic [STEP_W-1:0] INIT_WAKE_STEPS = 4'd4;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd13;

	typedef struct packed {
		logic       is_init;
		logic       is_data;
		logic [7:0] code;
	} entry_t;

	typedef struct packed {
		logic [CFG_W-1:0] command_pulse;
		logic [CFG_W-1:0] data_pulse;
		logic [CFG_W-1:0] command_settle;
		logic [CFG_W-1:0] slow_command_extra;
		logic [CFG_W-1:0] power_up_wait;
		logic [CFG_W-1:0] init_second_wait;
		logic [CFG_W-1:0] data_gap;
	} cfg_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} qstat_t;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] code;
		unique case (idx)
			3'd0:    code = CMD_FUNCTION_SET;
			3'd1:    code = CMD_DISPLAY_ON;
			3'd2:    code = CMD_CURSOR_SHIFT;
			3'd3:    code = CMD_CLEAR;
			default: code = CMD_RETURN_HOME;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/clns_front.sv -----
// Front stage: accepts requests and turns them into queue entries.
module clns_front import clns_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] byte_value,
	output logic       push,
	output entry_t     push_entry,
	input  logic       push_ready
);

	logic   valid_s1;
	entry_t entry_s1;
	entry_t entry_d;

	always_comb begin
		entry_d = '0;
		unique case (req_type)
			REQ_INIT: begin
				entry_d.is_init = 1'b1;
			end
			REQ_COMMAND: begin
				entry_d.code = byte_value;
			end
			REQ_DATA: begin
				entry_d.is_data = 1'b1;
				entry_d.code = byte_value;
			end
			default: begin
				entry_d.code = byte_value | SET_POSITION_BIT;
			end
		endcase
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

// ----- rtl/clns_queue.sv -----
// Two-entry queue between the request front stage and the strobe sequencer.
module clns_queue import clns_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   push_ready,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry,
	output qstat_t status
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && head_valid;

	assign status.full = !push_ready;
	assign status.empty = !head_valid;
	assign status.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/clns_back.sv -----
// Back stage: steps through the nibble strobes of the entry at the queue head.
module clns_back import clns_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    head_valid,
	input  entry_t                  head_entry,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CFG_W-1:0]        wait_before,
	output logic                    reg_select,
	output logic [3:0]              nibble,
	output logic [CFG_W-1:0]        pulse_cycles,
	output logic [WAIT_AFTER_W-1:0] wait_after,
	output logic                    last
);

	logic [STEP_W-1:0]       step_q;
	logic [STEP_W-1:0]       step_m4;
	logic                    wake_phase;
	logic [7:0]              code;
	logic                    load;
	logic [CFG_W-1:0]        wb_d;
	logic [3:0]              nib_d;
	logic [CFG_W-1:0]        pulse_d;
	logic [WAIT_AFTER_W-1:0] wa_d;
	logic                    last_d;

	logic                    valid_q;
	logic [CFG_W-1:0]        wb_q;
	logic                    rs_q;
	logic [3:0]              nib_q;
	logic [CFG_W-1:0]        pulse_q;
	logic [WAIT_AFTER_W-1:0] wa_q;
	logic                    last_q;

	// Init steps 4 and up walk the command table two nibbles per byte.
	assign step_m4 = step_q - INIT_WAKE_STEPS;
	assign wake_phase = head_entry.is_init && (step_q < INIT_WAKE_STEPS);
	assign code = head_entry.is_init ? init_byte(step_m4[3:1]) : head_entry.code;

	always_comb begin
		wb_d = '0;
		if (head_entry.is_init && step_q == '0) begin
			wb_d = cfg.power_up_wait;
		end
		pulse_d = head_entry.is_data ? cfg.data_pulse : cfg.command_pulse;
		if (wake_phase) begin
			nib_d = (step_q == INIT_WAKE_STEPS - 4'd1) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE;
			if (step_q == '0) begin
				wa_d = {1'b0, cfg.init_second_wait};
			end else begin
				wa_d = {1'b0, cfg.command_settle};
			end
		end else begin
			nib_d = step_q[0] ? code[3:0] : code[7:4];
			if (!step_q[0]) begin
				wa_d = '0;
			end else if (head_entry.is_data) begin
				wa_d = {1'b0, cfg.data_gap};
			end else if (code < SLOW_COMMAND_LIMIT) begin
				wa_d = {1'b0, cfg.command_settle} + {1'b0, cfg.slow_command_extra};
			end else begin
				wa_d = {1'b0, cfg.command_settle};
			end
		end
		last_d = head_entry.is_init ? (step_q == INIT_LAST_STEP) : step_q[0];
	end

	assign load = head_valid && (!valid_q || out_ready);
	assign pop = load && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				step_q <= last_d ? '0 : step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wb_q <= wb_d;
			rs_q <= head_entry.is_data;
			nib_q <= nib_d;
			pulse_q <= pulse_d;
			wa_q <= wa_d;
			last_q <= last_d;
		end
	end

	assign out_valid = valid_q;
	assign wait_before = wb_q;
	assign reg_select = rs_q;
	assign nibble = nib_q;
	assign pulse_cycles = pulse_q;
	assign wait_after = wa_q;
	assign last = last_q;

endmodule

// ----- rtl/char_lcd_nibble_sequencer_unit.sv -----
// Top level of the character LCD nibble sequencer: timing registers and the three stages.
//
//   channel   handshake             payload
//   request   in_valid / in_ready   req_type, byte_value
//   strobe    out_valid / out_ready wait_before, reg_select, nibble, pulse_cycles,
//                                   wait_after, last
//   config    cfg_write             cfg_index, cfg_data
//
// One strobe beat leaves per cycle while out_ready holds: a command, data or position
// request is two beats and init is fourteen, set by the single step counter of the
// back stage. A request reaches the outputs through the front register, a queue slot
// and the back stage output registers. Reset clears the queue, the step counter and
// the valid flags and loads the timing registers with their defaults.
// While the output stalls, requests flow into the two-entry queue until it is full.
module char_lcd_nibble_sequencer_unit import clns_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic [7:0]              byte_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CFG_W-1:0]        wait_before,
	output logic                    reg_select,
	output logic [3:0]              nibble,
	output logic [CFG_W-1:0]        pulse_cycles,
	output logic [WAIT_AFTER_W-1:0] wait_after,
	output logic                    last,
	input  logic                    cfg_write,
	input  logic [REG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	`include "char_lcd_nibble_sequencer_unit_assert.svh"

	cfg_t   cfg_q;
	logic   push;
	entry_t push_entry;
	logic   push_ready;
	logic   pop;
	logic   head_valid;
	entry_t head_entry;
	qstat_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_pulse <= RST_COMMAND_PULSE;
			cfg_q.data_pulse <= RST_DATA_PULSE;
			cfg_q.command_settle <= RST_COMMAND_SETTLE;
			cfg_q.slow_command_extra <= RST_SLOW_COMMAND_EXTRA;
			cfg_q.power_up_wait <= RST_POWER_UP_WAIT;
			cfg_q.init_second_wait <= RST_INIT_SECOND_WAIT;
			cfg_q.data_gap <= RST_DATA_GAP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COMMAND_PULSE:      cfg_q.command_pulse <= cfg_data;
				REG_DATA_PULSE:         cfg_q.data_pulse <= cfg_data;
				REG_COMMAND_SETTLE:     cfg_q.command_settle <= cfg_data;
				REG_SLOW_COMMAND_EXTRA: cfg_q.slow_command_extra <= cfg_data;
				REG_POWER_UP_WAIT:      cfg_q.power_up_wait <= cfg_data;
				REG_INIT_SECOND_WAIT:   cfg_q.init_second_wait <= cfg_data;
				REG_DATA_GAP:           cfg_q.data_gap <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	clns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.byte_value (byte_value),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	clns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.status     (q_status)
	);

	clns_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.wait_before  (wait_before),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.pulse_cycles (pulse_cycles),
		.wait_after   (wait_after),
		.last         (last)
	);

	// The queue never holds more than its two slots.
	`CLNS_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count != 2'd3)
	// A nonzero pre-wait only comes with the first power-up nibble.
	`CLNS_ASSERT_NOW(a_prewait_first_init, out_valid && wait_before != '0,
		!reg_select && nibble == WAKE_NIBBLE && !last)
	// The high nibble of a character never carries a post-wait.
	`CLNS_ASSERT_NOW(a_data_high_no_wait, out_valid && reg_select && !last,
		wait_after == '0)
	// An accepted request always lands in the front register.
	`CLNS_ASSERT_NEXT(a_front_loads, in_valid && in_ready, push)

endmodule
